// ----- rtl/core/bpp_pkg.sv -----
// Shared types and constants of the biosensor packet parser.
// Used by every module in rtl/core; depends on nothing else.
package bpp_pkg;

    localparam int PAYLOAD_DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam logic [7:0] SKIP_BYTE     = 8'h55;
    localparam logic [7:0] CODE_RAW      = 8'h80;
    localparam logic [7:0] CODE_RATE     = 8'h03;
    localparam logic [7:0] CODE_QUALITY  = 8'h02;
    localparam logic [7:0] RAW_LEN       = 8'd2;
    localparam logic [7:0] QUALITY_RESET = 8'd200;

    localparam logic [7:0] MAX_LEN_RESET = 8'd180;

    localparam logic [1:0] REG_MAX_LEN     = 2'd0;
    localparam logic [1:0] REG_RAW_EN      = 2'd1;
    localparam logic [1:0] REG_RATE_EN     = 2'd2;
    localparam logic [1:0] REG_QUALITY_EN  = 2'd3;

    localparam logic [1:0] KIND_RAW     = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic       is_walk;
        logic [7:0] len;
    } cmd_t;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic raw_en;
        logic rate_en;
        logic quality_en;
    } back_cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic               rate_seen;
        logic [7:0]         heart_rate;
        logic               quality_seen;
        logic [7:0]         signal_quality;
        logic               last;
    } result_t;

endpackage

// ----- rtl/core/biosensor_packet_parser.sv -----
// Biosensor packet parser: one received byte per cycle while full is low. After a good
// checksum the walk reads each code and its next byte, skips 0x55 fillers, reads both
// bytes of a raw sample and ends with the summary, waiting while the result queue is
// full; a bad checksum queues an error word. Data bytes of the next packet wait while
// the single payload memory is walked. Reset (rst_n, asynchronous) clears framing,
// queues and latches (quality 200) and restores the registers.
module biosensor_packet_parser #(
    parameter int PAYLOAD_DEPTH = bpp_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         kind,
    output logic signed [15:0] sample,
    output logic               rate_seen,
    output logic [7:0]         heart_rate,
    output logic               quality_seen,
    output logic [7:0]         signal_quality,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bpp_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

    logic [7:0] max_len_reg;
    logic       raw_en_reg;
    logic       rate_en_reg;
    logic       quality_en_reg;
    logic       cfg_write;
    back_cfg_t  back_cfg;

    mem_wr_t    mem_wr;
    logic       cmd_push;
    cmd_t       cmd_wdata;
    logic [CMD_W-1:0] cmd_rbits;
    cmd_t       cmd_rdata;
    logic       cmd_full;
    logic       cmd_empty;
    logic       cmd_pop;
    logic       walk_done;
    logic       res_push;
    result_t    res_wdata;
    logic [RES_W-1:0] res_rbits;
    result_t    res_rdata;
    logic       res_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_LEN_RESET;
            raw_en_reg     <= 1'b1;
            rate_en_reg    <= 1'b1;
            quality_en_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_LEN:    max_len_reg    <= pwdata[7:0];
                REG_RAW_EN:     raw_en_reg     <= pwdata[0];
                REG_RATE_EN:    rate_en_reg    <= pwdata[0];
                REG_QUALITY_EN: quality_en_reg <= pwdata[0];
                default:        max_len_reg    <= max_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_LEN:    prdata = {24'd0, max_len_reg};
            REG_RAW_EN:     prdata = {31'd0, raw_en_reg};
            REG_RATE_EN:    prdata = {31'd0, rate_en_reg};
            REG_QUALITY_EN: prdata = {31'd0, quality_en_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign back_cfg.raw_en     = raw_en_reg;
    assign back_cfg.rate_en    = rate_en_reg;
    assign back_cfg.quality_en = quality_en_reg;

    bpp_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .rx_byte         (rx_byte),
        .full            (full),
        .max_payload_len (max_len_reg),
        .walk_done       (walk_done),
        .mem_wr          (mem_wr),
        .cmd_push        (cmd_push),
        .cmd_data        (cmd_wdata),
        .cmd_full        (cmd_full)
    );

    bpp_fifo #(
        .WIDTH(CMD_W)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rbits),
        .empty (cmd_empty)
    );

    assign cmd_rdata = cmd_t'(cmd_rbits);

    bpp_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .mem_wr    (mem_wr),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .walk_done (walk_done)
    );

    bpp_fifo #(
        .WIDTH(RES_W)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rbits),
        .empty (empty)
    );

    assign res_rdata      = result_t'(res_rbits);
    assign kind           = res_rdata.kind;
    assign sample         = res_rdata.sample;
    assign rate_seen      = res_rdata.rate_seen;
    assign heart_rate     = res_rdata.heart_rate;
    assign quality_seen   = res_rdata.quality_seen;
    assign signal_quality = res_rdata.signal_quality;
    assign last           = res_rdata.last;

endmodule

// ----- rtl/core/bpp_fifo.sv -----
// Small synchronous queue of packed words, used for the command and result queues.
// Depends on bpp_pkg for its depth.
module bpp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import bpp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/bpp_front.sv -----
// Front part of the packet parser: framing, payload capture and checksum test.
// Depends on bpp_pkg; writes the payload memory held in bpp_back.
module bpp_front #(
    parameter int PAYLOAD_DEPTH = bpp_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      rx_byte,
    output logic            full,
    input  logic [7:0]      max_payload_len,
    input  logic            walk_done,
    output bpp_pkg::mem_wr_t mem_wr,
    output logic            cmd_push,
    output bpp_pkg::cmd_t   cmd_data,
    input  logic            cmd_full
);
    import bpp_pkg::*;

    localparam logic [8:0] DEPTH_LIMIT = 9'(PAYLOAD_DEPTH);

    typedef enum logic [4:0] {
        PH_SYNC1 = 5'b00001,
        PH_SYNC2 = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] expected_len_reg, expected_len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic       pending_reg, pending_next;
    logic       accept;
    logic [7:0] count_inc;
    logic       bad_len;
    logic       csum_ok;

    // Data bytes wait while a walk still owns the payload memory.
    assign full = ((phase_reg == PH_DATA) && pending_reg) ||
                  ((phase_reg == PH_CHECK) && cmd_full);
    assign accept    = push && !full;
    assign count_inc = count_reg + 8'd1;
    assign bad_len   = (rx_byte == 8'd0) || (rx_byte > max_payload_len) ||
                       ({1'b0, rx_byte} > DEPTH_LIMIT);
    assign csum_ok   = (rx_byte == ~sum_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        expected_len_next = expected_len_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        pending_next      = pending_reg;
        mem_wr.we         = 1'b0;
        mem_wr.addr       = count_reg;
        mem_wr.data       = rx_byte;
        cmd_push          = 1'b0;
        cmd_data.is_walk  = csum_ok;
        cmd_data.len      = expected_len_reg;

        if (walk_done)
        begin
            pending_next = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN:
                begin
                    if (bad_len)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        expected_len_next = rx_byte;
                        count_next        = 8'd0;
                        sum_next          = 8'd0;
                        phase_next        = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    mem_wr.we  = 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc >= expected_len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    cmd_push   = 1'b1;
                    phase_next = PH_SYNC1;
                    if (csum_ok)
                    begin
                        pending_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            expected_len_reg <= 8'd0;
            count_reg        <= 8'd0;
            sum_reg          <= 8'd0;
            pending_reg      <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            expected_len_reg <= expected_len_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            pending_reg      <= pending_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.we |-> !pending_reg)
        else $error("payload written while a walk owns the memory");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_data.is_walk) |=> pending_reg)
        else $error("walk queued without marking the memory busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> pending_reg)
        else $error("walk finished with none outstanding");

endmodule

// ----- rtl/core/bpp_back.sv -----
// Back part of the packet parser: payload memory, payload walk and result build.
// Depends on bpp_pkg; takes commands from the front through a bpp_fifo.
module bpp_back #(
    parameter int PAYLOAD_DEPTH = bpp_pkg::PAYLOAD_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bpp_pkg::back_cfg_t cfg,
    input  logic               cmd_empty,
    input  bpp_pkg::cmd_t      cmd_data,
    output logic               cmd_pop,
    input  bpp_pkg::mem_wr_t   mem_wr,
    input  logic               res_full,
    output logic               res_push,
    output bpp_pkg::result_t   res_data,
    output logic               walk_done
);
    import bpp_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    typedef enum logic [9:0] {
        W_IDLE     = 10'b0000000001,
        W_CODE_RD  = 10'b0000000010,
        W_CODE_CHK = 10'b0000000100,
        W_ARG_RD   = 10'b0000001000,
        W_ARG_CHK  = 10'b0000010000,
        W_HI_RD    = 10'b0000100000,
        W_LO_RD    = 10'b0001000000,
        W_EMIT_RAW = 10'b0010000000,
        W_SUMMARY  = 10'b0100000000,
        W_ERROR    = 10'b1000000000
    } walk_state_t;

    logic [7:0]  payload_mem [PAYLOAD_DEPTH];
    logic [7:0]  mem_q_reg;
    logic [AW-1:0] rd_addr;

    walk_state_t state_reg, state_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  hi_reg, hi_next;
    logic        rseen_reg, rseen_next;
    logic        qseen_reg, qseen_next;
    logic [7:0]  rval_reg, rval_next;
    logic [7:0]  qval_reg, qval_next;
    logic        rate_valid_reg, rate_valid_next;
    logic [7:0]  rate_reg, rate_next;
    logic [7:0]  quality_reg, quality_next;

    logic        at_end;
    logic [8:0]  idx_inc;
    logic [9:0]  arg_end;
    logic        take_rate;
    logic        take_quality;
    logic        sum_rate_valid;
    logic [7:0]  sum_rate;
    logic [7:0]  sum_quality;

    assign at_end  = (idx_reg >= {1'b0, len_reg});
    assign idx_inc = idx_reg + 9'd1;
    assign arg_end = {1'b0, idx_inc} + {2'b00, mem_q_reg};

    // The second sample byte sits one past the index; its read is held while stalled.
    assign rd_addr = ((state_reg == W_LO_RD) || (state_reg == W_EMIT_RAW)) ?
                     idx_inc[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_wr.we)
        begin
            payload_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
        end
        mem_q_reg <= payload_mem[rd_addr];
    end

    assign take_rate      = rseen_reg && cfg.rate_en;
    assign take_quality   = qseen_reg && cfg.quality_en;
    assign sum_rate_valid = rate_valid_reg || take_rate;
    assign sum_rate       = take_rate ? rval_reg : rate_reg;
    assign sum_quality    = take_quality ? qval_reg : quality_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        code_next       = code_reg;
        hi_next         = hi_reg;
        rseen_next      = rseen_reg;
        qseen_next      = qseen_reg;
        rval_next       = rval_reg;
        qval_next       = qval_reg;
        rate_valid_next = rate_valid_reg;
        rate_next       = rate_reg;
        quality_next    = quality_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        walk_done       = 1'b0;
        res_data        = '0;

        case (state_reg)
            W_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    len_next = cmd_data.len;
                    idx_next = 9'd0;
                    if (cmd_data.is_walk)
                    begin
                        rseen_next = 1'b0;
                        qseen_next = 1'b0;
                        state_next = W_CODE_RD;
                    end
                    else
                    begin
                        state_next = W_ERROR;
                    end
                end
            end
            W_CODE_RD:
            begin
                state_next = at_end ? W_SUMMARY : W_CODE_CHK;
            end
            W_CODE_CHK:
            begin
                idx_next = idx_inc;
                if (mem_q_reg == SKIP_BYTE)
                begin
                    state_next = W_CODE_RD;
                end
                else
                begin
                    code_next  = mem_q_reg;
                    state_next = W_ARG_RD;
                end
            end
            W_ARG_RD:
            begin
                state_next = at_end ? W_SUMMARY : W_ARG_CHK;
            end
            W_ARG_CHK:
            begin
                idx_next = idx_inc;
                if (!code_reg[7])
                begin
                    // Short code: the byte just read is its single value.
                    if (code_reg == CODE_RATE)
                    begin
                        rseen_next = 1'b1;
                        rval_next  = mem_q_reg;
                    end
                    else if (code_reg == CODE_QUALITY)
                    begin
                        qseen_next = 1'b1;
                        qval_next  = mem_q_reg;
                    end
                    state_next = W_CODE_RD;
                end
                else if (arg_end > {2'b00, len_reg})
                begin
                    state_next = W_SUMMARY;
                end
                else if ((code_reg == CODE_RAW) && (mem_q_reg == RAW_LEN) && cfg.raw_en)
                begin
                    state_next = W_HI_RD;
                end
                else
                begin
                    idx_next   = arg_end[8:0];
                    state_next = W_CODE_RD;
                end
            end
            W_HI_RD:
            begin
                state_next = W_LO_RD;
            end
            W_LO_RD:
            begin
                hi_next    = mem_q_reg;
                state_next = W_EMIT_RAW;
            end
            W_EMIT_RAW:
            begin
                res_data.kind   = KIND_RAW;
                res_data.sample = {hi_reg, mem_q_reg};
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    idx_next   = idx_reg + 9'd2;
                    state_next = W_CODE_RD;
                end
            end
            W_SUMMARY:
            begin
                res_data.kind           = KIND_SUMMARY;
                res_data.rate_seen      = rseen_reg;
                res_data.heart_rate     = sum_rate_valid ? sum_rate : 8'd0;
                res_data.quality_seen   = qseen_reg;
                res_data.signal_quality = sum_quality;
                res_data.last           = 1'b1;
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    walk_done       = 1'b1;
                    rate_valid_next = sum_rate_valid;
                    rate_next       = sum_rate;
                    quality_next    = sum_quality;
                    state_next      = W_IDLE;
                end
            end
            W_ERROR:
            begin
                res_data.kind = KIND_ERROR;
                res_data.last = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            idx_reg        <= 9'd0;
            len_reg        <= 8'd0;
            rseen_reg      <= 1'b0;
            qseen_reg      <= 1'b0;
            rate_valid_reg <= 1'b0;
            rate_reg       <= 8'd0;
            quality_reg    <= QUALITY_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            len_reg        <= len_next;
            rseen_reg      <= rseen_next;
            qseen_reg      <= qseen_next;
            rate_valid_reg <= rate_valid_next;
            rate_reg       <= rate_next;
            quality_reg    <= quality_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        hi_reg   <= hi_next;
        rval_reg <= rval_next;
        qval_reg <= qval_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == W_IDLE))
        else $error("command taken while a walk is still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> (res_push && (res_data.kind == KIND_SUMMARY)))
        else $error("walk finished without its summary word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != W_IDLE) |-> (idx_reg <= {1'b0, len_reg}))
        else $error("walk index ran past the payload end");

endmodule
